@@ sv/ascii_setpoint_frame_parser_core_defines.svh @@
// Assertion macros for the setpoint frame parser.
`ifndef ASCII_SETPOINT_FRAME_PARSER_CORE_DEFINES_SVH
`define ASCII_SETPOINT_FRAME_PARSER_CORE_DEFINES_SVH

// Checked outside reset only.
`define ASFP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASFP_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/asfp_pkg.sv @@
package asfp_pkg;

  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_B    = 8'h62;  // 'b'
  localparam logic [7:0] CH_C    = 8'h63;  // 'c'
  localparam logic [7:0] CH_D    = 8'h64;  // 'd'
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  localparam int FRAME_LEN  = 7;
  localparam int POS_W      = 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
  localparam int NUM_DIGITS = 4;
  localparam int MAG_W      = 14;
  localparam int SP_W       = 15;
  localparam int SP_MAX     = 9999;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DELIM = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;
  localparam logic [1:0] ST_CMD   = 2'd3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_POS,
    CMD_NEG,
    CMD_BAD
  } cmd_t;

  // Classified frame handed from the front to the back
  typedef struct packed {
    logic                        delim_ok;
    logic                        digits_ok;
    cmd_t                        cmd;
    logic [NUM_DIGITS-1:0][3:0]  digit;   // digit[0] is the thousands digit
  } frame_rec_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             push;
  } front_stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

@@ sv/asfp_front.sv @@
module asfp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [7:0]               in_byte,
  output logic                     in_ready,
  input  logic                     q_ready,
  output logic                     push,
  output asfp_pkg::frame_rec_t     rec,
  output asfp_pkg::front_stat_t    stat
);
  import asfp_pkg::*;

  logic [POS_W-1:0] pos;
  logic [7:0]       frame_buf [0:FRAME_LEN-2];
  logic             xfer;
  logic             is_lt;

  assign in_ready = q_ready;
  assign xfer     = in_valid && q_ready;
  assign is_lt    = (in_byte == CH_LT);
  assign push     = xfer && !is_lt && (pos == LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (xfer) begin
      if (is_lt) begin
        pos <= POS_W'(1);
      end else if (pos == LAST_POS) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  // The closing byte is classified straight from the input, never stored
  always_ff @(posedge clk) begin
    if (xfer) begin
      if (is_lt) begin
        frame_buf[0] <= in_byte;
      end else if (pos != LAST_POS) begin
        frame_buf[pos] <= in_byte;
      end
    end
  end

  always_comb begin
    rec.delim_ok  = (frame_buf[0] == CH_LT) && (in_byte == CH_B);
    rec.digits_ok = 1'b1;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (!is_digit(frame_buf[k+2])) begin
        rec.digits_ok = 1'b0;
      end
      rec.digit[k] = frame_buf[k+2][3:0];
    end
    if (frame_buf[1] == CH_C) begin
      rec.cmd = CMD_POS;
    end else if (frame_buf[1] == CH_D) begin
      rec.cmd = CMD_NEG;
    end else begin
      rec.cmd = CMD_BAD;
    end
  end

  assign stat.pos  = pos;
  assign stat.push = push;

endmodule

@@ sv/asfp_fifo.sv @@
module asfp_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  input  asfp_pkg::frame_rec_t  wr_data,
  output logic                  wr_ready,
  output logic                  rd_valid,
  output asfp_pkg::frame_rec_t  rd_data,
  input  logic                  rd_ready
);
  import asfp_pkg::*;

  frame_rec_t          mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  count;
  logic                do_wr;
  logic                do_rd;

  assign wr_ready = (count != FIFO_CW'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + FIFO_CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule

@@ sv/asfp_back.sv @@
module asfp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  asfp_pkg::frame_rec_t         rec,
  output logic                         q_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [asfp_pkg::SP_W-1:0] setpoint,
  output logic [1:0]                   status
);
  import asfp_pkg::*;

  logic                   load;
  logic [MAG_W-1:0]       mag;
  logic signed [SP_W-1:0] sp_next;
  logic [1:0]             status_next;

  assign q_ready = !out_valid || out_ready;
  assign load    = q_valid && q_ready;

  assign mag = MAG_W'(rec.digit[0]) * MAG_W'(1000)
             + MAG_W'(rec.digit[1]) * MAG_W'(100)
             + MAG_W'(rec.digit[2]) * MAG_W'(10)
             + MAG_W'(rec.digit[3]);

  always_comb begin
    sp_next     = '0;
    status_next = ST_OK;
    priority if (!rec.delim_ok) begin
      status_next = ST_DELIM;
    end else if (!rec.digits_ok) begin
      status_next = ST_DIGIT;
    end else begin
      unique case (rec.cmd)
        CMD_POS: sp_next = $signed({1'b0, mag});
        CMD_NEG: sp_next = -$signed({1'b0, mag});
        default: status_next = ST_CMD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      setpoint <= sp_next;
      status   <= status_next;
    end
  end

endmodule

@@ sv/ascii_setpoint_frame_parser_core.sv @@
// Throughput: one byte per cycle, sustained, with m_tready held high.
// After its closing byte transfers, the result of a frame passes through the frame
// queue and then the output register.
// A two-entry frame queue lets the byte side keep running while a result waits.
// Reset (rst, synchronous): position returns to 0, queue empties, m_tvalid drops.
`include "ascii_setpoint_frame_parser_core_defines.svh"

module ascii_setpoint_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] setpoint_hundredths, [15] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import asfp_pkg::*;

  logic                   push;
  logic                   q_wr_ready;
  logic                   q_rd_valid;
  logic                   q_rd_ready;
  frame_rec_t             front_rec;
  frame_rec_t             back_rec;
  front_stat_t            fstat;
  logic signed [SP_W-1:0] setpoint;

  asfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .q_ready  (q_wr_ready),
    .push     (push),
    .rec      (front_rec),
    .stat     (fstat)
  );

  asfp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_data  (front_rec),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_data  (back_rec),
    .rd_ready (q_rd_ready)
  );

  asfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_rd_valid),
    .rec       (back_rec),
    .q_ready   (q_rd_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .setpoint  (setpoint),
    .status    (m_tuser)
  );

  assign m_tdata = {1'b0, setpoint};

  `ASFP_CHECK_ALWAYS(a_idle_after_reset, rst |=> !m_tvalid,
    "result valid right after reset")
  `ASFP_CHECK(a_err_zero, m_tvalid && (m_tuser != ST_OK) |-> (setpoint == '0),
    "error result with nonzero setpoint")
  `ASFP_CHECK(a_ok_range,
    m_tvalid && (m_tuser == ST_OK) |-> (setpoint <= SP_MAX) && (setpoint >= -SP_MAX),
    "setpoint out of range")
  `ASFP_CHECK(a_lt_restart,
    s_tvalid && s_tready && (s_tdata == CH_LT) |=> (fstat.pos == POS_W'(1)),
    "start byte did not restart frame")
  `ASFP_CHECK(a_push_last, fstat.push |-> (fstat.pos == LAST_POS),
    "frame pushed before last slot")

endmodule
